>>> hdl/address_symbol_range_lookup_defines.svh
// Assertion macros for the address symbol range lookup checker.
`ifndef ADDRESS_SYMBOL_RANGE_LOOKUP_DEFINES_SVH
`define ADDRESS_SYMBOL_RANGE_LOOKUP_DEFINES_SVH

// Clocked check, quiet while reset is high.
`define ASRL_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASRL_CHECK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/asrl_pkg.sv
// Package: widths, types and codes of the address symbol range lookup.
package asrl_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = 11;
   localparam int ADDR_W      = 32;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;
endpackage

>>> hdl/asrl_if.sv
// Channel interfaces: lookup request and lookup response.
interface asrl_req_if;
   import asrl_pkg::*;
   logic     valid;
   logic     ready;
   logic     op;
   idx_type  entry_index;
   addr_type address;

   modport source (output valid, output op, output entry_index, output address,
                   input ready);
   modport sink   (input valid, input op, input entry_index, input address,
                   output ready);
endinterface

interface asrl_rsp_if;
   import asrl_pkg::*;
   logic     valid;
   logic     ready;
   logic     found;
   idx_type  symbol_index;
   addr_type offset;

   modport source (output valid, output found, output symbol_index, output offset,
                   input ready);
   modport sink   (input valid, input found, input symbol_index, input offset,
                   output ready);
endinterface

>>> hdl/address_symbol_range_lookup.sv
// Lookup: an accept step, a scan of the entries examined (1..entry_count, at most the table depth), then a result step.
// The block takes no new request until a lookup is through; the scan walks the start table
// through its single read port at one entry and one compare pair per cycle.
// A table write is done at its transfer, and an empty table skips the scan.
// Reset (synchronous, active high) clears the sequencer, the result valid and entry_count;
// the start table is not cleared and is undefined until written.
module address_symbol_range_lookup (
   input  logic                     clock,
   input  logic                     reset,
   asrl_req_if.sink                 req_ch,
   asrl_rsp_if.source               rsp_ch,
   input  logic                     csr_wr_en,
   input  asrl_pkg::count_type      csr_wr_data
);
   import asrl_pkg::*;

   // Sequencer state codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   count_type  count_ff;
   addr_type   addr_ff, addr_in;      // address being looked up
   addr_type   prev_ff, prev_in;      // start carried from the previous entry
   idx_type    prev_idx_ff, prev_idx_in;
   idx_type    cmp_idx_ff, cmp_idx_in;  // entry whose start is on the read port
   idx_type    last_idx_ff, last_idx_in;
   logic       first_ff, first_in;    // first scan cycle: previous start is entry 0
   logic       found_ff, found_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_found_ff, rsp_found_in;
   idx_type    rsp_idx_ff, rsp_idx_in;
   addr_type   rsp_offset_ff, rsp_offset_in;

   logic       req_xfer;
   logic       wr_en;
   logic       rd_en;
   idx_type    rd_addr;
   addr_type   rd_data;
   count_type  n_sat;
   addr_type   prev_sel;
   idx_type    prev_idx_sel;
   logic       hit;

   // Saturate the entry count at the table depth
   assign n_sat = (count_ff > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign wr_en        = req_xfer && (req_ch.op == OP_WRITE);

   // Shared compare unit: previous start <= address <= current start
   assign prev_sel     = first_ff ? rd_data : prev_ff;
   assign prev_idx_sel = first_ff ? '0 : prev_idx_ff;
   assign hit          = (addr_ff >= prev_sel) && (addr_ff <= rd_data);

   asrl_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_start_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_ch.entry_index),
      .wr_data (req_ch.address),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      prev_in       = prev_ff;
      prev_idx_in   = prev_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      last_idx_in   = last_idx_ff;
      first_in      = first_ff;
      found_in      = found_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_offset_in = rsp_offset_ff;
      rd_en         = 1'b0;
      rd_addr       = cmp_idx_ff + IDX_W'(1);
      // Drop the result once the sink takes the transfer
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_ch.op == OP_LOOKUP)) begin
               addr_in = req_ch.address;
               if (n_sat == '0) begin
                  // Empty table: report not found right away
                  found_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // Issue the read of entry 0 and start the scan
                  rd_en       = 1'b1;
                  rd_addr     = '0;
                  cmp_idx_in  = '0;
                  first_in    = 1'b1;
                  last_idx_in = IDX_W'(n_sat - COUNT_W'(1));
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // Hold the matched start and index for the result
               prev_in     = prev_sel;
               prev_idx_in = prev_idx_sel;
               found_in    = 1'b1;
               state_in    = ST_DONE;
            end else begin
               // Advance: this entry becomes the previous one
               prev_in     = rd_data;
               prev_idx_in = cmp_idx_ff;
               first_in    = 1'b0;
               if (cmp_idx_ff == last_idx_ff) begin
                  found_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  cmp_idx_in = cmp_idx_ff + IDX_W'(1);
                  rd_en      = 1'b1;
               end
            end
         end
         ST_DONE: begin
            // Load the output register when it is free or being drained
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_idx_in    = found_ff ? prev_idx_ff : '0;
               rsp_offset_in = found_ff ? (addr_ff - prev_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      prev_ff       <= prev_in;
      prev_idx_ff   <= prev_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      last_idx_ff   <= last_idx_in;
      first_ff      <= first_in;
      found_ff      <= found_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.symbol_index = rsp_idx_ff;
   assign rsp_ch.offset       = rsp_offset_ff;
endmodule

>>> hdl/asrl_ram.sv
// Generic single write port, single read port RAM with registered read.
module asrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> hdl/asrl_checker.sv
// Port-level checker for the address symbol range lookup, with its bind.
`include "address_symbol_range_lookup_defines.svh"

module asrl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_found,
   input asrl_pkg::idx_type  rsp_symbol_index,
   input asrl_pkg::addr_type rsp_offset
);
   import asrl_pkg::*;

   // Reset empties the output register
   `ASRL_CHECK_RST(a_rsp_empty_after_reset, reset |=> !rsp_valid, "result valid after reset")

   // A lookup transfer closes the request side while it is worked on
   `ASRL_CHECK(a_busy_after_lookup, (req_valid && req_ready && req_op == OP_LOOKUP) |=> !req_ready, "request ready right after a lookup")

   // A miss carries zero index and zero offset
   `ASRL_CHECK(a_miss_is_zero, (rsp_valid && !rsp_found) |-> (rsp_symbol_index == '0 && rsp_offset == '0), "miss with nonzero payload")

   // A stalled result holds
   `ASRL_CHECK(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) && $stable(rsp_symbol_index) && $stable(rsp_offset)), "stalled result changed")
endmodule

bind address_symbol_range_lookup asrl_checker u_asrl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_op           (req_ch.op),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_found        (rsp_ch.found),
   .rsp_symbol_index (rsp_ch.symbol_index),
   .rsp_offset       (rsp_ch.offset)
);

>>> tb/address_symbol_range_lookup_checker.sv
// Checker: predicts lookup responses from observed transfers and compares them.
module address_symbol_range_lookup_checker (
   input  logic                clock,
   input  logic                reset,
   asrl_req_if                 req_mon,
   asrl_rsp_if                 rsp_mon,
   input  logic                csr_wr_en,
   input  asrl_pkg::count_type csr_wr_data,
   output int                  outstanding,
   output int                  fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import asrl_pkg::*;

   typedef struct packed {
      logic     found;
      idx_type  symbol_index;
      addr_type offset;
   } lookup_result_t;

   addr_type       start_shadow [TABLE_DEPTH];
   count_type      entry_limit;
   lookup_result_t pending_results [$];

   // Walk the shadow table the way the block does, carrying the previous start.
   function automatic lookup_result_t scan_table(addr_type addr);
      lookup_result_t res;
      int             span;
      addr_type       prev_start;
      int             prev_slot;
      res = '0;
      span = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_limit);
      if (span == 0) return res;
      prev_start = start_shadow[0];
      prev_slot  = 0;
      for (int i = 0; i < span; i++) begin
         if (addr >= prev_start && addr <= start_shadow[i]) begin
            res.found        = 1'b1;
            res.symbol_index = idx_type'(prev_slot);
            res.offset       = addr - prev_start;
            return res;
         end
         prev_start = start_shadow[i];
         prev_slot  = i;
      end
      return res;
   endfunction

   initial begin
      foreach (start_shadow[i]) start_shadow[i] = '0;
      entry_limit = '0;
      outstanding = 0;
      fail_count  = 0;
   end

   always @(posedge clock) begin
      lookup_result_t want;
      if (reset) begin
         entry_limit = '0;
         pending_results.delete();
      end else begin
         if (csr_wr_en) entry_limit = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("response transfer with no lookup pending");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_mon.found);
                  fail_count++;
               end
               if (rsp_mon.symbol_index !== want.symbol_index) begin
                  $error("symbol_index: expected %0d, got %0d",
                         want.symbol_index, rsp_mon.symbol_index);
                  fail_count++;
               end
               if (rsp_mon.offset !== want.offset) begin
                  $error("offset: expected %h, got %h", want.offset, rsp_mon.offset);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_WRITE)
               start_shadow[req_mon.entry_index] = req_mon.address;
            else
               pending_results = {pending_results, scan_table(req_mon.address)};
         end
      end
      outstanding = pending_results.size();
   end
endmodule

>>> tb/address_symbol_range_lookup_test.sv
// Testbench top: drives table loads, entry counts and lookups, and reports the verdict.
module address_symbol_range_lookup_test;
   timeunit 1ns;
   timeprecision 1ps;
   import asrl_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 480;
   // Ascending slots loaded for the large-count scans.
   localparam int FILL_SLOTS   = 64;
   // A full-table scan runs with no transfer; keep the limit well above it.
   localparam int STALL_LIMIT  = 6000;
   // Margin for the last table write to retire after its transfer.
   localparam int DRAIN_CYCLES = 4;

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   count_type csr_wr_data;
   int        outstanding;
   int        fail_count;

   // Idle odds in percent; start with a slow sender and a slower receiver.
   int        snd_idle_pct = 11;
   int        rcv_idle_pct = 59;
   int        stall_cycles = 0;
   int        items_sent   = 0;

   // Generation-side view of the table, used to aim lookups at real ranges and to bound the count.
   addr_type  table_img [TABLE_DEPTH];
   bit        written   [TABLE_DEPTH];
   int        lookup_span = 0;

   asrl_req_if req_bus();
   asrl_rsp_if rsp_bus();

   address_symbol_range_lookup DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   address_symbol_range_lookup_checker lookup_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // Receiver: decide each cycle whether to take a response.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Watchdog: end the run if nothing transfers for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Length of the written run of slots starting at slot 0.
   function automatic int written_prefix();
      int k;
      k = 0;
      while (k < TABLE_DEPTH && written[k]) k++;
      return k;
   endfunction

   // Pick an address close to, or between, the starts that the scan will see.
   function automatic addr_type near_entry_address();
      int       j;
      int       pick;
      addr_type lo;
      if (lookup_span == 0) return $urandom;
      j    = $urandom_range(lookup_span - 1);
      lo   = table_img[j];
      pick = $urandom_range(9);
      if (pick < 4) return lo + addr_type'($urandom_range(2)) - 1;
      if (pick < 8 && j + 1 < lookup_span && table_img[j + 1] > lo)
         return lo + addr_type'($urandom_range(table_img[j + 1] - lo));
      return $urandom;
   endfunction

   // Present one item and hold it until the block takes it. Entered and left at a
   // falling edge; valid stays high so back-to-back transfers need no toggle.
   task automatic send_item(input logic op, input idx_type slot, input addr_type addr);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.entry_index <= slot;
      req_bus.address     <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (op == OP_WRITE) begin
         table_img[slot] = addr;
         written[slot]   = 1'b1;
      end
   endtask

   // Drop valid, let every response come back and the last write retire.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Program the entry count; only ever called with the block idle.
   task automatic set_entry_count(input count_type value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      lookup_span = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
   endtask

   // One random phase: load a short, mostly ascending table, set the count, probe it.
   task automatic run_random_phase();
      addr_type fresh [12];
      addr_type cursor;
      addr_type step;
      int       n;
      int       rot;
      int       gap_bits;
      int       span;
      int       probes;
      int       r;
      n        = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
      cursor   = $urandom_range(32'hC000_0000);
      gap_bits = $urandom_range(4, 24);
      for (int j = 0; j < n; j++) begin
         fresh[j] = cursor;
         step = ($urandom_range(9) == 0) ? '0 : addr_type'($urandom_range(1 << gap_bits));
         cursor = (cursor > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : cursor + step;
      end
      // Now and then break the ordering on purpose.
      if (n > 1 && $urandom_range(5) == 0) fresh[$urandom_range(n - 1)] = $urandom;
      rot = (n > 0) ? $urandom_range(n - 1) : 0;
      for (int k = 0; k < n; k++)
         send_item(OP_WRITE, idx_type'((k + rot) % n), fresh[(k + rot) % n]);
      // Stray load anywhere in the table.
      if ($urandom_range(9) == 0) send_item(OP_WRITE, idx_type'($urandom), $urandom);

      // Never let the scan reach a slot that has not been loaded.
      if (n == 0)
         span = 0;
      else if ($urandom_range(4) != 0)
         span = n;
      else
         span = $urandom_range(1, written_prefix());
      set_entry_count(count_type'(span));

      probes = $urandom_range(4, 12);
      repeat (probes) begin
         r = $urandom_range(99);
         if (r < 70)
            send_item(OP_LOOKUP, idx_type'($urandom), near_entry_address());
         else if (r < 82)
            send_item(OP_LOOKUP, idx_type'($urandom), $urandom);
         else if (r < 90)
            send_item(OP_LOOKUP, idx_type'($urandom), $urandom_range(1) ? '1 : '0);
         else
            send_item(OP_WRITE, idx_type'($urandom), $urandom);
      end
   endtask

   // Fill the low slots in ascending order over the whole address space, probe
   // inside the filled span at the largest counts, the saturating ones among them,
   // then scan the filled span to its end.
   task automatic run_full_table();
      count_type big_counts [3];
      addr_type  lo_start;
      addr_type  hi_start;
      big_counts[0] = count_type'(TABLE_DEPTH);
      big_counts[1] = '1;
      big_counts[2] = count_type'(TABLE_DEPTH - 1);
      for (int j = 0; j < FILL_SLOTS; j++)
         send_item(OP_WRITE, idx_type'(j),
                   (addr_type'(j) << 26) | addr_type'($urandom_range(32'h03FF_FFFF)));
      lo_start = table_img[0];
      hi_start = table_img[FILL_SLOTS - 1];
      foreach (big_counts[c]) begin
         set_entry_count(big_counts[c]);
         // Hit within the filled span so the scan stops on a loaded slot.
         repeat (4)
            send_item(OP_LOOKUP, idx_type'($urandom),
                      lo_start + addr_type'($urandom_range(hi_start - lo_start)));
      end
      set_entry_count(count_type'(FILL_SLOTS));
      repeat (4) send_item(OP_LOOKUP, idx_type'($urandom), near_entry_address());
      send_item(OP_LOOKUP, '0, '1);
   endtask

   initial begin
      int random_base;
      int done;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_WRITE;
      req_bus.entry_index = '0;
      req_bus.address     = '0;
      rsp_bus.ready       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table after reset: every lookup misses.
      send_item(OP_LOOKUP, '1, '0);
      send_item(OP_LOOKUP, '0, '1);

      // Small table with a repeated start and a start near the top of the space.
      send_item(OP_WRITE, idx_type'(0), 32'h0000_1000);
      send_item(OP_WRITE, idx_type'(1), 32'h0000_2000);
      send_item(OP_WRITE, idx_type'(2), 32'h0000_2000);
      send_item(OP_WRITE, idx_type'(3), 32'hFFFF_FFF0);
      set_entry_count(count_type'(4));
      send_item(OP_LOOKUP, '0, 32'h0000_0FFF);
      send_item(OP_LOOKUP, '0, 32'h0000_1000);
      send_item(OP_LOOKUP, '0, 32'h0000_1800);
      send_item(OP_LOOKUP, '0, 32'h0000_2000);
      send_item(OP_LOOKUP, '0, 32'h0000_2001);
      send_item(OP_LOOKUP, '0, 32'hFFFF_FFF0);
      send_item(OP_LOOKUP, '0, 32'hFFFF_FFFF);

      // Out-of-order start: the scan runs as is, with no sorting check.
      send_item(OP_WRITE, idx_type'(1), 32'h0000_0800);
      send_item(OP_LOOKUP, '0, 32'h0000_0900);
      send_item(OP_LOOKUP, '0, 32'h0000_1800);

      // Single entry at address zero.
      send_item(OP_WRITE, idx_type'(0), 32'h0000_0000);
      set_entry_count(count_type'(1));
      send_item(OP_LOOKUP, '0, 32'h0000_0000);
      send_item(OP_LOOKUP, '0, 32'h0000_0001);

      // Random phases: slow receiver first, then slow sender, then full rate.
      random_base = items_sent;
      done        = 0;
      while (done < RANDOM_ITEMS) begin
         if (done < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 11;
            rcv_idle_pct = 59;
         end else if (done < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 59;
            rcv_idle_pct = 11;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         run_random_phase();
         done = items_sent - random_base;
      end

      run_full_table();

      // Drain everything, then give the verdict.
      wait_idle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
